FILE: hw/rtl/krt_pkg.sv
// shared types and constants of the keyed record table
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

  localparam int DEPTH       = 16;
  localparam int WEIGHT_BITS = 20;
  localparam int KEY_W       = 64;
  localparam int PAY_W       = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_MAX    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [WEIGHT_BITS-1:0] weight;
    logic [PAY_W-1:0]       payload;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

`default_nettype wire

FILE: hw/rtl/krt_if.sv
// input and result channel interfaces of the keyed record table
`timescale 1ns / 1ps
`default_nettype none

interface krt_in_if import krt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [KEY_W-1:0]       key;
  logic [WEIGHT_BITS-1:0] weight;
  logic [PAY_W-1:0]       payload;

  modport source (output valid, opcode, key, weight, payload, input ready);
  modport sink   (input valid, opcode, key, weight, payload, output ready);
endinterface

interface krt_out_if import krt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [KEY_W-1:0]       rec_key;
  logic [WEIGHT_BITS-1:0] rec_weight;
  logic [PAY_W-1:0]       rec_payload;
  logic                   last;

  modport source (output valid, status, rec_key, rec_weight, rec_payload, last,
                  input ready);
  modport sink   (input valid, status, rec_key, rec_weight, rec_payload, last,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/krt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_record_table.sv
// keyed record table: ordered record store with insert, lookup, delete and max query
// Records live in one RAM, one record per row, kept in insertion order; a
// single read port walks the table one entry per clock unless the result
// channel stalls. An insert is written and answered in the run state once the
// output register is free. Lookup, delete and max scan the live entries; delete
// then moves each record behind the removed one up a row. The next transaction
// is taken once the current one is finished, while its last result may still
// sit in the output register. Lookup, delete and max on an empty table answer
// status empty, a missed key status not found and an insert into a full table
// status full, each with zero record fields.
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table import krt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);

  state_t           state_r, state_nxt;
  opcode_t          op_r;
  rec_t             in_rec_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  rec_t             pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  rec_t             best_r, best_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  rec_t             out_rec_r;
  logic             out_last_r;

  logic             emit;
  status_t          emit_status;
  rec_t             emit_rec;
  logic             emit_last;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  rec_t             dout;

  logic             accept;
  logic             out_free;
  logic             done;
  logic             match;
  logic             empty;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;

  // handshake and scan helpers
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign dout        = rec_t'(ram_rdata);
  assign done        = (idx_r == count_r);
  assign match       = (dout.key == in_rec_r.key);
  assign empty       = (count_r == '0);
  assign idx_inc     = idx_r + CNT_W'(1);
  assign idx_dec     = idx_r - CNT_W'(1);

  // record store, read address follows the next scan index
  krt_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(REC_W'(ram_wdata)),
    .raddr(idx_nxt[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (op_r != OP_INSERT && empty) begin
          if (out_free) state_nxt = S_IDLE;
        end else begin
          unique case (op_r) inside
            OP_INSERT: if (out_free) state_nxt = S_IDLE;
            OP_LOOKUP, OP_MAX: if (done && out_free) state_nxt = S_IDLE;
            OP_DELETE: begin
              if (done && out_free) begin
                state_nxt = S_IDLE;
              end else if (!done && match && out_free) begin
                state_nxt = S_SHIFT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        if (done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    best_nxt    = best_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_rec    = '0;
    emit_last   = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = count_r[IDX_W-1:0];
    ram_wdata   = in_rec_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt    = '0;
        pend_v_nxt = 1'b0;
      end
      S_RUN: begin
        if (op_r != OP_INSERT && empty) begin
          emit        = out_free;
          emit_status = ST_EMPTY;
        end else begin
          unique case (op_r)
            OP_INSERT: begin
              if (out_free) begin
                emit = 1'b1;
                if (count_r == CNT_W'(DEPTH)) begin
                  emit_status = ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                  emit_rec  = in_rec_r;
                end
              end
            end
            OP_LOOKUP: begin
              if (done) begin
                emit = out_free;
                if (pend_v_r) emit_rec = pend_r;
                else emit_status = ST_NOTFOUND;
              end else if (match && pend_v_r) begin
                // flush the held match, keep the new one until the scan ends
                if (out_free) begin
                  emit      = 1'b1;
                  emit_rec  = pend_r;
                  emit_last = 1'b0;
                  pend_nxt  = dout;
                  idx_nxt   = idx_inc;
                end
              end else begin
                if (match) begin
                  pend_nxt   = dout;
                  pend_v_nxt = 1'b1;
                end
                idx_nxt = idx_inc;
              end
            end
            OP_DELETE: begin
              if (done) begin
                emit        = out_free;
                emit_status = ST_NOTFOUND;
              end else if (match) begin
                if (out_free) begin
                  emit     = 1'b1;
                  emit_rec = dout;
                  idx_nxt  = idx_inc;
                end
              end else begin
                idx_nxt = idx_inc;
              end
            end
            OP_MAX: begin
              if (done) begin
                emit     = out_free;
                emit_rec = best_r;
              end else begin
                if (idx_r == '0 || dout.weight > best_r.weight) begin
                  best_nxt = dout;
                end
                idx_nxt = idx_inc;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      S_SHIFT: begin
        // move each later record up one row
        if (done) begin
          count_nxt = count_r - CNT_W'(1);
          idx_nxt   = '0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_dec[IDX_W-1:0];
          ram_wdata = dout;
          idx_nxt   = idx_inc;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r             <= opcode_t'(in_ch.opcode);
      in_rec_r.key     <= in_ch.key;
      in_rec_r.weight  <= in_ch.weight;
      in_rec_r.payload <= in_ch.payload;
    end
    pend_r <= pend_nxt;
    best_r <= best_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_rec_r    <= emit_rec;
      out_last_r   <= emit_last;
    end
  end

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.rec_key     = out_rec_r.key;
  assign out_ch.rec_weight  = out_rec_r.weight;
  assign out_ch.rec_payload = out_rec_r.payload;
  assign out_ch.last        = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("record count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> (count_r == $past(count_r) + CNT_W'(1)) ||
                          (count_r == $past(count_r) - CNT_W'(1)))
    else $error("record count moved by more than one");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r <= count_r))
    else $error("scan index past live entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_status == ST_FULL) |-> (count_r == CNT_W'(DEPTH)))
    else $error("full reported with room in table");

  a_no_emit_on_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !emit)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
